FILE: src/elsr_pkg.sv
`default_nettype none
package elsr_pkg;

	localparam int CODE_W = 10;
	localparam int READ_W = 16;
	localparam int SP_W = 16;
	localparam int DUTY_W = 16;

	// Q16 gains: KP folds both ADC references, the divider ratio and the 100 W scale.
	localparam logic [27:0] KP_Q16 = 28'd177470177;
	localparam logic [20:0] KV_Q16 = 21'd1466696;

	localparam logic [9:0] R_SCALE = 10'd1000;
	localparam logic [4:0] LOW_DUTY_LIMIT = 5'd16;
	localparam logic [4:0] LOW_DUTY_JUMP = 5'd23;

	localparam logic MODE_POWER = 1'b0;
	localparam logic MODE_RESIST = 1'b1;

	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SETPOINT = 1'b1;

	typedef struct packed {
		logic [CODE_W-1:0] current_code;
		logic [CODE_W-1:0] voltage_code;
	} in_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [READ_W-1:0] reading;
		logic              no_current;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_CMP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: src/electronic_load_step_regulator_top.sv
// Each input transfer is worked through in turn: three passes through the shared
// multiplier, a compare state and 17 compare-subtract steps of the shared restoring
// divider, then the result waits in the done state until the output register is free.
// No new input is taken until that result has been loaded into the output register.
// Reset (arst_n low) clears the duty, mode and setpoint to zero and empties the output.
`default_nettype none
module electronic_load_step_regulator_top #(
	parameter int ADC_BITS = 10,
	parameter int DUTY_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire elsr_pkg::in_t       in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output elsr_pkg::out_t           out_data,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [15:0]         cfg_data
);

	localparam int P_W = 2 * ADC_BITS;
	localparam int MA_W = (P_W > 26) ? P_W : 26;
	localparam int MB_W = (P_W > 28) ? P_W : 28;
	localparam int PR_W = MA_W + MB_W;
	localparam int CMP_W = PR_W + 16;
	localparam int DIV_W = P_W + 32;
	localparam int Q_W = elsr_pkg::READ_W + 1;
	localparam int CNT_W = $clog2(Q_W);
	localparam logic [63:0] FS_L = (64'd1 << ADC_BITS) - 64'd1;
	localparam logic [63:0] FS2_L = FS_L * FS_L;
	localparam logic [P_W-1:0] FS2 = FS2_L[P_W-1:0];
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

	elsr_pkg::state_t state_q, state_d;

	logic                       mode_q;
	logic [elsr_pkg::SP_W-1:0]  setpoint_q;
	logic [ADC_BITS-1:0]        i_q, v_q;
	logic [PR_W-1:0]            r0_q, r1_q, r2_q;
	logic [DIV_W-1:0]           rem_q, dsh_q;
	logic [Q_W-1:0]             quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [DUTY_BITS-1:0]       duty_q;
	logic                       zero_q;
	logic                       out_valid_q;
	elsr_pkg::out_t             out_q;

	logic [25:0]           cur_ext, volt_ext;
	logic [MA_W-1:0]       mul_a;
	logic [MB_W-1:0]       mul_b;
	logic [PR_W-1:0]       mul_p;
	logic                  load_out;
	logic [CMP_W-1:0]      cmp_lhs, cmp_rhs;
	logic                  rise;
	logic [DUTY_BITS-1:0]  duty_d;
	logic [PR_W+3:0]       load_x10;
	logic [DIV_W-1:0]      div_n, div_dsh;
	logic [DIV_W-1:0]      rem_sub;
	logic                  div_take;
	logic [elsr_pkg::READ_W-1:0] reading_d;

	assign cur_ext = {16'b0, in_data.current_code};
	assign volt_ext = {16'b0, in_data.voltage_code};

	always_comb begin
		state_d = state_q;
		case (state_q)
			elsr_pkg::ST_IDLE: if (in_valid) state_d = elsr_pkg::ST_MUL0;
			elsr_pkg::ST_MUL0: state_d = elsr_pkg::ST_MUL1;
			elsr_pkg::ST_MUL1: state_d = elsr_pkg::ST_MUL2;
			elsr_pkg::ST_MUL2: state_d = elsr_pkg::ST_CMP;
			elsr_pkg::ST_CMP: state_d = elsr_pkg::ST_DIV;
			elsr_pkg::ST_DIV: if (cnt_q == '0) state_d = elsr_pkg::ST_DONE;
			elsr_pkg::ST_DONE: if (!out_valid_q || out_ready) state_d = elsr_pkg::ST_IDLE;
			default: state_d = elsr_pkg::ST_IDLE;
		endcase
	end

	// Operand selection for the shared multiplier, plus in_ready and the output load strobe.
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			elsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			elsr_pkg::ST_MUL0: begin
				if (mode_q == elsr_pkg::MODE_POWER) begin
					mul_a = MA_W'(i_q);
					mul_b = MB_W'(v_q);
				end else begin
					mul_a = MA_W'(v_q);
					mul_b = MB_W'(elsr_pkg::KV_Q16);
				end
			end
			elsr_pkg::ST_MUL1: begin
				if (mode_q == elsr_pkg::MODE_POWER) begin
					mul_a = MA_W'(r0_q);
					mul_b = MB_W'(elsr_pkg::KP_Q16);
				end else begin
					mul_a = MA_W'(setpoint_q);
					mul_b = MB_W'(elsr_pkg::R_SCALE);
				end
			end
			elsr_pkg::ST_MUL2: begin
				if (mode_q == elsr_pkg::MODE_POWER) begin
					mul_a = MA_W'(setpoint_q);
					mul_b = MB_W'(FS2);
				end else begin
					mul_a = MA_W'(r1_q);
					mul_b = MB_W'(i_q);
				end
			end
			elsr_pkg::ST_DONE: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign mul_p = PR_W'(mul_a) * PR_W'(mul_b);

	// Power mode compares load with the shifted target; resistance mode compares
	// v*KV*65535 with 1000*setpoint*i shifted, which avoids a division.
	always_comb begin
		if (mode_q == elsr_pkg::MODE_POWER) begin
			cmp_lhs = CMP_W'(r1_q);
			cmp_rhs = CMP_W'(r2_q) << 16;
			rise = cmp_lhs < cmp_rhs;
		end else begin
			cmp_lhs = (CMP_W'(r0_q) << 16) - CMP_W'(r0_q);
			cmp_rhs = CMP_W'(r2_q) << 16;
			rise = cmp_lhs > cmp_rhs;
		end
	end

	always_comb begin
		duty_d = duty_q;
		if (rise) begin
			if (duty_q != DUTY_MAX) duty_d = duty_q + DUTY_BITS'(1);
		end else if (mode_q == elsr_pkg::MODE_POWER) begin
			if (duty_q < DUTY_BITS'(elsr_pkg::LOW_DUTY_LIMIT)) begin
				duty_d = DUTY_BITS'(elsr_pkg::LOW_DUTY_JUMP);
			end else begin
				duty_d = duty_q - DUTY_BITS'(1);
			end
		end else if (duty_q != '0) begin
			duty_d = duty_q - DUTY_BITS'(1);
		end
	end

	// Dividend and starting divisor; the divisor starts shifted up by 32 bits.
	always_comb begin
		load_x10 = ((PR_W + 4)'(r1_q) << 3) + ((PR_W + 4)'(r1_q) << 1);
		if (mode_q == elsr_pkg::MODE_POWER) begin
			div_n = DIV_W'(load_x10);
			div_dsh = DIV_W'(FS2) << 32;
		end else begin
			div_n = DIV_W'(r0_q);
			div_dsh = DIV_W'(i_q) << 32;
		end
	end

	assign div_take = rem_q >= dsh_q;
	assign rem_sub = rem_q - dsh_q;

	always_comb begin
		if (mode_q == elsr_pkg::MODE_RESIST && zero_q) begin
			reading_d = '0;
		end else if (quo_q[Q_W-1]) begin
			reading_d = '1;
		end else begin
			reading_d = quo_q[Q_W-2:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= elsr_pkg::ST_IDLE;
			mode_q <= elsr_pkg::MODE_POWER;
			setpoint_q <= '0;
			duty_q <= '0;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					elsr_pkg::REG_MODE: mode_q <= cfg_data[0];
					elsr_pkg::REG_SETPOINT: setpoint_q <= cfg_data;
					default: mode_q <= mode_q;
				endcase
			end
			if (state_q == elsr_pkg::ST_CMP) begin
				duty_q <= duty_d;
				cnt_q <= CNT_W'(Q_W - 1);
			end else if (state_q == elsr_pkg::ST_DIV) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			elsr_pkg::ST_IDLE: begin
				if (in_valid) begin
					i_q <= cur_ext[ADC_BITS-1:0];
					v_q <= volt_ext[ADC_BITS-1:0];
					zero_q <= (cur_ext[ADC_BITS-1:0] == '0);
				end
			end
			elsr_pkg::ST_MUL0: r0_q <= mul_p;
			elsr_pkg::ST_MUL1: r1_q <= mul_p;
			elsr_pkg::ST_MUL2: r2_q <= mul_p;
			elsr_pkg::ST_CMP: begin
				rem_q <= div_n;
				dsh_q <= div_dsh;
				quo_q <= '0;
			end
			elsr_pkg::ST_DIV: begin
				if (div_take) rem_q <= rem_sub;
				quo_q <= {quo_q[Q_W-2:0], div_take};
				dsh_q <= dsh_q >> 1;
			end
			elsr_pkg::ST_DONE: begin
				if (load_out) begin
					out_q.duty <= elsr_pkg::DUTY_W'(duty_q);
					out_q.reading <= reading_d;
					out_q.no_current <= zero_q;
				end
			end
			default: begin
				quo_q <= quo_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import elsr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int LONG_HOLD = 400;
	localparam int MAX_REPORTS = 200;

	// Q16 gains: power gain folds both references, the divider and the 100 W scale.
	localparam longint unsigned CODE_FS = (64'd1 << CODE_W) - 1;
	localparam logic [CODE_W-1:0] CODE_TOP = '1;
	localparam longint unsigned PWR_GAIN = 64'd177470177;
	localparam longint unsigned VOLT_GAIN = 64'd1466696;
	localparam longint unsigned READ_CAP = 64'd65535;

	class duty_step_board;
		logic              mode_q = MODE_POWER;
		logic [SP_W-1:0]   setpoint_q = '0;
		logic [DUTY_W-1:0] duty_q = '0;
		out_t              expected_steps[$];
		int                errors = 0;

		function void note_register(logic idx, logic [15:0] value);
			if (idx == REG_MODE) begin
				mode_q = value[0];
			end else begin
				setpoint_q = value[SP_W-1:0];
			end
		endfunction

		// Works out the duty move and the reading for one accepted sample.
		function void note_sample(in_t sample);
			longint unsigned cur, volt, prod, load, target, lhs, rhs, rd, sp;
			logic rise;
			out_t step;
			cur = 64'(sample.current_code);
			volt = 64'(sample.voltage_code);
			sp = 64'(setpoint_q);
			prod = cur * volt;
			if (mode_q == MODE_POWER) begin
				load = prod * PWR_GAIN;
				target = (sp * CODE_FS * CODE_FS) << 16;
				rise = load < target;
				rd = (load * 10) / ((CODE_FS * CODE_FS) << 16);
			end else begin
				lhs = volt * VOLT_GAIN * 64'd65535;
				rhs = (64'd1000 * sp * cur) << 16;
				rise = lhs > rhs;
				rd = (cur == 0) ? 64'd0 : (volt * VOLT_GAIN) / (cur << 16);
			end
			if (rd > READ_CAP)
				rd = READ_CAP;
			if (rise) begin
				if (duty_q != '1)
					duty_q = duty_q + 1'b1;
			end else if (mode_q == MODE_POWER && duty_q < DUTY_W'(16)) begin
				// A low duty that must fall in power mode jumps up to 23.
				duty_q = DUTY_W'(23);
			end else if (duty_q != '0) begin
				duty_q = duty_q - 1'b1;
			end
			step.duty = duty_q;
			step.reading = rd[READ_W-1:0];
			step.no_current = (cur == 0);
			expected_steps.push_back(step);
		endfunction

		function void report(string what, longint unsigned want, longint unsigned got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void check_step(out_t got);
			out_t want;
			if (expected_steps.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual duty %0d reading %0d flag %0b",
						$time, got.duty, got.reading, got.no_current);
				return;
			end
			want = expected_steps.pop_front();
			if (got.duty !== want.duty)
				report("duty", 64'(want.duty), 64'(got.duty));
			if (got.reading !== want.reading)
				report("reading", 64'(want.reading), 64'(got.reading));
			if (got.no_current !== want.no_current)
				report("no_current", 64'(want.no_current), 64'(got.no_current));
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_t        out_data;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_MODE;
	logic [15:0] cfg_data = '0;

	duty_step_board board = new;
	bit allow_gaps = 1'b0;
	bit hold_request = 1'b0;

	electronic_load_step_regulator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!allow_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 20);
		return $urandom_range(30, 120);
	endfunction

	function automatic logic [CODE_W-1:0] draw_code();
		int r;
		int code;
		r = $urandom_range(0, 99);
		if (r < 70)
			code = $urandom_range(0, 32'(CODE_FS));
		else if (r < 85)
			code = $urandom_range(0, 15);
		else if (r < 92)
			code = 0;
		else
			code = 32'(CODE_FS);
		return code[CODE_W-1:0];
	endfunction

	initial begin : result_sink
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_step(out_data);
			if (stall > 0) begin
				stall--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = pick_gap();
			end
			out_ready <= arst_n && (stall == 0);
		end
	end

	task automatic write_reg(logic idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.note_register(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(logic [CODE_W-1:0] cur, logic [CODE_W-1:0] volt);
		in_t sample;
		int gap;
		sample.current_code = cur;
		sample.voltage_code = volt;
		in_valid <= 1'b1;
		in_data <= sample;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_sample(sample);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (board.expected_steps.size() != 0)
			@(posedge clk);
	endtask

	// Registers change only with the block empty; upper bits ride along on the mode write.
	task automatic configure(logic mode, logic [15:0] setpoint);
		logic [15:0] mode_word;
		in_valid <= 1'b0;
		wait_drained();
		repeat (30) @(posedge clk);
		mode_word = 16'($urandom_range(0, 16'hFFFF));
		mode_word[0] = mode;
		write_reg(REG_MODE, mode_word);
		write_reg(REG_SETPOINT, setpoint);
	endtask

	initial begin : stimulus
		logic        mode;
		logic [15:0] setpoint;
		int          count;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Resistance mode: falls at zero duty stay at zero; zero current with
		// a voltage counts as infinite resistance, with no voltage it falls.
		configure(MODE_RESIST, 16'hFFFF);
		send_sample('0, '0);
		send_sample(CODE_TOP, '0);
		send_sample('0, CODE_TOP);
		send_sample('0, '0);
		send_sample(CODE_W'(1), CODE_TOP);
		send_sample(CODE_TOP, CODE_TOP);
		configure(MODE_RESIST, 16'h0000);
		send_sample(CODE_TOP, CODE_TOP);
		send_sample('0, '0);

		// Zero power target: every step falls, so the duty keeps jumping back up.
		configure(MODE_POWER, 16'h0000);
		send_sample('0, '0);
		send_sample(CODE_TOP, CODE_TOP);
		send_sample(CODE_TOP, '0);
		send_sample('0, CODE_TOP);
		send_sample(CODE_W'(1), CODE_W'(1));
		send_sample(10'h2AA, 10'h155);
		send_sample(10'h155, 10'h2AA);
		send_sample(CODE_TOP, CODE_W'(1));
		send_sample(CODE_W'(1), CODE_TOP);
		send_sample(CODE_TOP, CODE_TOP);
		configure(MODE_POWER, 16'hFFFF);
		send_sample(CODE_TOP, CODE_TOP);
		send_sample('0, '0);

		for (int ph = 0; ph < 8; ph++) begin
			mode = ph[0] ? MODE_RESIST : MODE_POWER;
			case (ph)
				2, 7: setpoint = 16'hFFFF;
				3, 6: setpoint = 16'h0000;
				4: setpoint = 16'($urandom_range(0, 3000));
				default: setpoint = 16'($urandom_range(0, 16'hFFFF));
			endcase
			configure(mode, setpoint);
			allow_gaps = (ph % 3 != 2);
			for (count = 0; count < 160; count++) begin
				// The sink holds off for a long while as samples keep coming.
				if (ph == 1 && count == 60)
					hold_request = 1'b1;
				// Let everything in flight come out before going on.
				if (ph == 4 && count == 80) begin
					in_valid <= 1'b0;
					wait_drained();
					@(posedge clk);
				end
				send_sample(draw_code(), draw_code());
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
